/* design/bffsa_pkg.sv */
// Shared constants and types of the flat-field stack accumulator.
package bffsa_pkg;

	localparam int NUM_PIXELS     = 65536;
	localparam int SAMPLE_BITS    = 16;
	localparam int FRAC_BITS      = 8;
	localparam int GAIN_BITS      = 16;
	localparam int GAIN_FRAC_BITS = 12;
	localparam int SUM_BITS       = 34;
	localparam int COUNT_BITS     = 16;
	localparam int MEAN_BITS      = 18;

	localparam int ADDR_W    = $clog2(NUM_PIXELS);
	localparam int ROW_W     = SAMPLE_BITS + FRAC_BITS;
	localparam int WGT_W     = FRAC_BITS + 1;
	localparam int MUL_A_W   = ROW_W;
	localparam int MUL_B_W   = GAIN_BITS;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int CONTRIB_W = SAMPLE_BITS + GAIN_BITS - GAIN_FRAC_BITS;
	localparam int MEM_W     = SUM_BITS + COUNT_BITS;
	localparam int DIV_CNT_W = $clog2(SUM_BITS + 1);

	localparam logic [WGT_W-1:0]      FRAC_ONE  = WGT_W'(2 ** FRAC_BITS);
	localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [MEAN_BITS-1:0]  MEAN_MAX  = '1;

	typedef enum logic {
		OP_ACCUMULATE = 1'b0,
		OP_READ       = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC_MAC,
		ST_ACC_WR,
		ST_DIV_LOAD,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		MAC_S00,
		MAC_S10,
		MAC_S01,
		MAC_S11,
		MAC_ROW0,
		MAC_ROW1,
		MAC_GAIN
	} mac_step_t;

endpackage

/* design/bffsa_item_if.sv */
// Input channel: one accumulate or read word per handshake.
interface bffsa_item_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] pixel_index;
	logic        contributes;
	logic        in_image;
	logic [7:0]  frac_x;
	logic [7:0]  frac_y;
	logic [15:0] sample_00;
	logic [15:0] sample_10;
	logic [15:0] sample_01;
	logic [15:0] sample_11;
	logic [15:0] flat_gain;

	modport source (
		output valid, opcode, pixel_index, contributes, in_image, frac_x, frac_y,
		output sample_00, sample_10, sample_01, sample_11, flat_gain,
		input  ready
	);
	modport sink (
		input  valid, opcode, pixel_index, contributes, in_image, frac_x, frac_y,
		input  sample_00, sample_10, sample_01, sample_11, flat_gain,
		output ready
	);
endinterface

/* design/bffsa_result_if.sv */
// Result channel: one normalized pixel word per handshake.
interface bffsa_result_if;
	logic        valid;
	logic        ready;
	logic [17:0] mean_value;
	logic [15:0] image_count;

	modport source (output valid, mean_value, image_count, input ready);
	modport sink (input valid, mean_value, image_count, output ready);
endinterface

/* design/bilinear_flat_field_stack_accumulator.sv */
// Mono image-stacking mean accumulator with bilinear sampling and flat-field gain.
//
// Each stack pixel keeps a 34-bit saturating sum and a 16-bit saturating
// count in one single-port-write, registered-read memory of NUM_PIXELS
// words. After reset the block first runs a clearing pass that writes zero
// to every word, one per cycle; cmd.ready stays low until it ends. The block
// then handles one word at a time. An accumulate word that does not
// contribute is taken and dropped, and the block stays idle. For a
// contributing accumulate word the memory read is issued at accept, a
// single shared multiply-accumulate unit walks seven steps (two per
// interpolated row, two for the vertical blend, one for the gain), and the
// updated sum and count are written back. With in_image low the sample is
// zero but the count still advances. A read word runs a restoring divider
// that retires one quotient bit per cycle over the 34 sum bits; a zero
// count divides by one and the mean saturates at 2^18-1. The result sits
// in an output register, so the next word is taken while a result waits on
// res.ready; a read only stalls when it finishes while the previous result
// is still unclaimed. Since only one word is in flight, no read-after-write
// hazard on the memory can arise.
module bilinear_flat_field_stack_accumulator (
	input  logic                  clk,
	input  logic                  arst_n,
	bffsa_item_if.sink            cmd,
	bffsa_result_if.source        res
);

	// state and sequencing
	bffsa_pkg::state_t    state_q, state_d;
	bffsa_pkg::mac_step_t step_q;
	logic [bffsa_pkg::ADDR_W-1:0]    clr_addr_q;
	logic [bffsa_pkg::DIV_CNT_W-1:0] div_cnt_q;

	// captured word
	logic                               op_q;
	logic                               addr_ok_q;
	logic                               in_image_q;
	logic [bffsa_pkg::ADDR_W-1:0]       addr_q;
	logic [bffsa_pkg::FRAC_BITS-1:0]    fx_q, fy_q;
	logic [bffsa_pkg::SAMPLE_BITS-1:0]  s00_q, s10_q, s01_q, s11_q;
	logic [bffsa_pkg::GAIN_BITS-1:0]    gain_q;

	// pixel memory: {sum, count}
	logic [bffsa_pkg::MEM_W-1:0] pix_mem [bffsa_pkg::NUM_PIXELS];
	logic [bffsa_pkg::MEM_W-1:0] mem_rd_q;
	logic                        mem_wr_en;
	logic [bffsa_pkg::ADDR_W-1:0] mem_wr_addr;
	logic [bffsa_pkg::MEM_W-1:0] mem_wr_data;

	logic [bffsa_pkg::SUM_BITS-1:0]   rd_sum;
	logic [bffsa_pkg::COUNT_BITS-1:0] rd_cnt;

	// multiply-accumulate unit
	logic [bffsa_pkg::MUL_A_W-1:0] mac_a;
	logic [bffsa_pkg::MUL_B_W-1:0] mac_b;
	logic                          mac_clr;
	logic [bffsa_pkg::PROD_W-1:0]  mac_acc_q, mac_acc_d;
	logic [bffsa_pkg::ROW_W-1:0]   row0_q, row1_q;
	logic [bffsa_pkg::WGT_W-1:0]   wx0, wy0;

	// write-back
	logic [bffsa_pkg::CONTRIB_W-1:0]  contrib;
	logic [bffsa_pkg::SUM_BITS:0]     sum_ext;
	logic [bffsa_pkg::SUM_BITS-1:0]   new_sum;
	logic [bffsa_pkg::COUNT_BITS-1:0] new_cnt;

	// divider
	logic [bffsa_pkg::COUNT_BITS-1:0] div_rem_q, div_den_q, cnt_keep_q;
	logic [bffsa_pkg::SUM_BITS-1:0]   div_quo_q;
	logic [bffsa_pkg::COUNT_BITS:0]   rem_sh, rem_sub;
	logic                             quo_bit;

	// output register
	logic                             out_valid_q;
	logic [bffsa_pkg::MEAN_BITS-1:0]  mean_q;
	logic [bffsa_pkg::COUNT_BITS-1:0] count_q;

	logic in_fire, out_load, addr_ok;

	assign in_fire = cmd.valid && cmd.ready;
	assign addr_ok = 32'(cmd.pixel_index) < 32'(bffsa_pkg::NUM_PIXELS);

	assign cmd.ready       = (state_q == bffsa_pkg::ST_IDLE);
	assign res.valid       = out_valid_q;
	assign res.mean_value  = mean_q;
	assign res.image_count = count_q;

	assign rd_sum = mem_rd_q[bffsa_pkg::MEM_W-1:bffsa_pkg::COUNT_BITS];
	assign rd_cnt = mem_rd_q[bffsa_pkg::COUNT_BITS-1:0];

	// next state and strobes
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			bffsa_pkg::ST_CLEAR: begin
				if (clr_addr_q == bffsa_pkg::ADDR_W'(bffsa_pkg::NUM_PIXELS - 1))
					state_d = bffsa_pkg::ST_IDLE;
			end
			bffsa_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (cmd.opcode == bffsa_pkg::OP_READ)
						state_d = bffsa_pkg::ST_DIV_LOAD;
					else if (addr_ok && cmd.contributes)
						state_d = bffsa_pkg::ST_ACC_MAC;
				end
			end
			bffsa_pkg::ST_ACC_MAC: begin
				if (step_q == bffsa_pkg::MAC_GAIN)
					state_d = bffsa_pkg::ST_ACC_WR;
			end
			bffsa_pkg::ST_ACC_WR:   state_d = bffsa_pkg::ST_IDLE;
			bffsa_pkg::ST_DIV_LOAD: state_d = bffsa_pkg::ST_DIV;
			bffsa_pkg::ST_DIV: begin
				if (div_cnt_q == bffsa_pkg::DIV_CNT_W'(bffsa_pkg::SUM_BITS - 1))
					state_d = bffsa_pkg::ST_OUT;
			end
			bffsa_pkg::ST_OUT: begin
				// hold until the previous result has been taken
				if (!out_valid_q || res.ready) begin
					out_load = 1'b1;
					state_d  = bffsa_pkg::ST_IDLE;
				end
			end
			default: state_d = bffsa_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bffsa_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// clearing pass address and sequencing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			step_q     <= bffsa_pkg::MAC_S00;
			div_cnt_q  <= '0;
		end else begin
			if (state_q == bffsa_pkg::ST_CLEAR)
				clr_addr_q <= clr_addr_q + bffsa_pkg::ADDR_W'(1);
			if (state_q == bffsa_pkg::ST_ACC_MAC)
				step_q <= bffsa_pkg::mac_step_t'(3'(step_q) + 3'd1);
			else
				step_q <= bffsa_pkg::MAC_S00;
			if (state_q == bffsa_pkg::ST_DIV)
				div_cnt_q <= div_cnt_q + bffsa_pkg::DIV_CNT_W'(1);
			else
				div_cnt_q <= '0;
		end
	end

	// capture the accepted word
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q       <= cmd.opcode;
			addr_ok_q  <= addr_ok;
			in_image_q <= cmd.in_image;
			addr_q     <= bffsa_pkg::ADDR_W'(cmd.pixel_index);
			fx_q       <= cmd.frac_x[bffsa_pkg::FRAC_BITS-1:0];
			fy_q       <= cmd.frac_y[bffsa_pkg::FRAC_BITS-1:0];
			s00_q      <= cmd.sample_00[bffsa_pkg::SAMPLE_BITS-1:0];
			s10_q      <= cmd.sample_10[bffsa_pkg::SAMPLE_BITS-1:0];
			s01_q      <= cmd.sample_01[bffsa_pkg::SAMPLE_BITS-1:0];
			s11_q      <= cmd.sample_11[bffsa_pkg::SAMPLE_BITS-1:0];
			gain_q     <= cmd.flat_gain;
		end
	end

	// pixel memory: read at accept, write during clearing and write-back
	assign mem_wr_en   = (state_q == bffsa_pkg::ST_CLEAR) ||
		(state_q == bffsa_pkg::ST_ACC_WR);
	assign mem_wr_addr = (state_q == bffsa_pkg::ST_CLEAR) ? clr_addr_q : addr_q;
	assign mem_wr_data = (state_q == bffsa_pkg::ST_CLEAR) ? '0 : {new_sum, new_cnt};

	always_ff @(posedge clk) begin
		if (in_fire)
			mem_rd_q <= pix_mem[bffsa_pkg::ADDR_W'(cmd.pixel_index)];
		if (mem_wr_en)
			pix_mem[mem_wr_addr] <= mem_wr_data;
	end

	// bilinear weights
	assign wx0 = bffsa_pkg::FRAC_ONE - bffsa_pkg::WGT_W'(fx_q);
	assign wy0 = bffsa_pkg::FRAC_ONE - bffsa_pkg::WGT_W'(fy_q);

	// operand select for the shared multiply-accumulate
	always_comb begin
		mac_a   = '0;
		mac_b   = '0;
		mac_clr = 1'b1;
		case (step_q)
			bffsa_pkg::MAC_S00: begin
				mac_a = bffsa_pkg::MUL_A_W'(s00_q);
				mac_b = bffsa_pkg::MUL_B_W'(wx0);
			end
			bffsa_pkg::MAC_S10: begin
				mac_a   = bffsa_pkg::MUL_A_W'(s10_q);
				mac_b   = bffsa_pkg::MUL_B_W'(fx_q);
				mac_clr = 1'b0;
			end
			bffsa_pkg::MAC_S01: begin
				mac_a = bffsa_pkg::MUL_A_W'(s01_q);
				mac_b = bffsa_pkg::MUL_B_W'(wx0);
			end
			bffsa_pkg::MAC_S11: begin
				mac_a   = bffsa_pkg::MUL_A_W'(s11_q);
				mac_b   = bffsa_pkg::MUL_B_W'(fx_q);
				mac_clr = 1'b0;
			end
			bffsa_pkg::MAC_ROW0: begin
				mac_a = row0_q;
				mac_b = bffsa_pkg::MUL_B_W'(wy0);
			end
			bffsa_pkg::MAC_ROW1: begin
				mac_a   = row1_q;
				mac_b   = bffsa_pkg::MUL_B_W'(fy_q);
				mac_clr = 1'b0;
			end
			bffsa_pkg::MAC_GAIN: begin
				// drop the 2*FRAC_BITS fraction of the blended sample
				mac_a = bffsa_pkg::MUL_A_W'(mac_acc_q[2*bffsa_pkg::FRAC_BITS +:
					bffsa_pkg::SAMPLE_BITS]);
				mac_b = gain_q;
			end
			default: begin
				mac_a = '0;
				mac_b = '0;
			end
		endcase
		mac_acc_d = (mac_clr ? '0 : mac_acc_q) +
			(bffsa_pkg::PROD_W'(mac_a) * bffsa_pkg::PROD_W'(mac_b));
	end

	always_ff @(posedge clk) begin
		if (state_q == bffsa_pkg::ST_ACC_MAC) begin
			mac_acc_q <= mac_acc_d;
			if (step_q == bffsa_pkg::MAC_S10)
				row0_q <= mac_acc_d[bffsa_pkg::ROW_W-1:0];
			if (step_q == bffsa_pkg::MAC_S11)
				row1_q <= mac_acc_d[bffsa_pkg::ROW_W-1:0];
		end
	end

	// write-back: saturating sum and count
	assign contrib = in_image_q ?
		mac_acc_q[bffsa_pkg::GAIN_FRAC_BITS +: bffsa_pkg::CONTRIB_W] : '0;
	assign sum_ext = {1'b0, rd_sum} + (bffsa_pkg::SUM_BITS + 1)'(contrib);
	assign new_sum = sum_ext[bffsa_pkg::SUM_BITS] ? bffsa_pkg::SUM_MAX :
		sum_ext[bffsa_pkg::SUM_BITS-1:0];
	assign new_cnt = (rd_cnt == bffsa_pkg::COUNT_MAX) ? rd_cnt :
		rd_cnt + bffsa_pkg::COUNT_BITS'(1);

	// restoring divider, one quotient bit per cycle
	assign rem_sh  = {div_rem_q, div_quo_q[bffsa_pkg::SUM_BITS-1]};
	assign rem_sub = rem_sh - {1'b0, div_den_q};
	assign quo_bit = (rem_sh >= {1'b0, div_den_q});

	always_ff @(posedge clk) begin
		if (state_q == bffsa_pkg::ST_DIV_LOAD) begin
			div_rem_q  <= '0;
			div_quo_q  <= addr_ok_q ? rd_sum : '0;
			div_den_q  <= (!addr_ok_q || rd_cnt == '0) ? bffsa_pkg::COUNT_BITS'(1) : rd_cnt;
			cnt_keep_q <= addr_ok_q ? rd_cnt : '0;
		end else if (state_q == bffsa_pkg::ST_DIV) begin
			div_rem_q <= quo_bit ? rem_sub[bffsa_pkg::COUNT_BITS-1:0] :
				rem_sh[bffsa_pkg::COUNT_BITS-1:0];
			div_quo_q <= {div_quo_q[bffsa_pkg::SUM_BITS-2:0], quo_bit};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mean_q  <= (|div_quo_q[bffsa_pkg::SUM_BITS-1:bffsa_pkg::MEAN_BITS]) ?
				bffsa_pkg::MEAN_MAX : div_quo_q[bffsa_pkg::MEAN_BITS-1:0];
			count_q <= (op_q == bffsa_pkg::OP_READ) ? cnt_keep_q : '0;
		end
	end

endmodule
